// ----- design/rpbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-4 partition boundary table: shared package
// Field widths, operation and status codes, control struct and the
// level-count and level-base helpers used by the sequencer and the top level.
// ----------------------------------------------------------------------------
package rpbt_pkg;

	localparam int MAX_LEVELS_DEF = 6;

	// request and response field widths
	localparam int SIZE_W    = 12;
	localparam int LEVEL_W   = 3;
	localparam int POS_W     = 11;
	localparam int BOUND_W   = 13;
	localparam int LCOUNT_W  = 3;
	localparam int LLEN_W    = 11;

	// left end of the whole range
	localparam logic signed [BOUND_W-1:0] BOUND_START = '1;

	typedef enum logic [0:0] {
		OP_BUILD = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_BUILT = 2'd2
	} status_t;

	// build sequencer status towards the controller
	typedef struct packed {
		logic busy;
		logic done;
	} bld_stat_t;

	// k = floor(log4 n) + 1, saturated at max_lv; n = 0 gives 1
	function automatic logic [3:0] levels_for(input logic [SIZE_W-1:0] n,
			input logic [3:0] max_lv);
		logic [3:0] k;
		k = 4'd1;
		for (int t = 0; t < SIZE_W / 2; t++) begin
			if (n[2*t +: 2] != 2'b00) begin
				k = 4'(t + 1);
			end
		end
		if (k > max_lv) begin
			k = max_lv;
		end
		return k;
	endfunction

	// first store entry of level lv in a table of k levels:
	// ((4^(lv-1) - 1) / 3) * 4^(k-lv+1) + lv - 1
	function automatic logic [31:0] level_base(input logic [3:0] lv, input logic [3:0] k);
		logic [31:0] pat;
		logic [3:0]  sh;
		pat = '0;
		for (int t = 0; t < 8; t++) begin
			if (4'(t + 1) < lv) begin
				pat[2*t] = 1'b1;
			end
		end
		sh = k - lv + 4'd1;
		return (pat << {sh, 1'b0}) + 32'(lv) - 32'd1;
	endfunction

endpackage

// ----- design/rpbt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-4 partition boundary table: channel interfaces
// Request, response and size-register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface rpbt_req_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [rpbt_pkg::LEVEL_W-1:0]   level;
	logic [rpbt_pkg::POS_W-1:0]     position;

	modport source (output valid, op, level, position, input ready);
	modport sink   (input valid, op, level, position, output ready);
endinterface

interface rpbt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rpbt_pkg::BOUND_W-1:0]  boundary;
	logic [rpbt_pkg::LCOUNT_W-1:0]        level_count;
	logic [rpbt_pkg::LLEN_W-1:0]          level_length;
	logic [1:0]                           status;

	modport source (output valid, boundary, level_count, level_length, status, input ready);
	modport sink   (input valid, boundary, level_count, level_length, status, output ready);
endinterface

interface rpbt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rpbt_pkg::SIZE_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- design/rpbt_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary store
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rpbt_store #(
	parameter int DEPTH  = 1371,
	parameter int ADDR_W = 11
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [ADDR_W-1:0]                    waddr,
	input  logic signed [rpbt_pkg::BOUND_W-1:0]  wdata,
	input  logic                                 re,
	input  logic [ADDR_W-1:0]                    raddr,
	output logic signed [rpbt_pkg::BOUND_W-1:0]  rdata
);

	logic signed [rpbt_pkg::BOUND_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/rpbt_build_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Build sequencer
// Walks the table from the coarsest level down, reading each parent
// interval end from the level above and writing its four child boundaries,
// one store write per cycle. The next parent end is prefetched during the
// writes of the current interval.
// ----------------------------------------------------------------------------
module rpbt_build_seq #(
	parameter int MAX_LEVELS = 6,
	parameter int ADDR_W     = 11,
	parameter int LVL_W      = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rpbt_pkg::SIZE_W-1:0]          problem_size,
	output rpbt_pkg::bld_stat_t                  stat,
	output logic [LVL_W-1:0]                     levels,
	output logic                                 we,
	output logic [ADDR_W-1:0]                    waddr,
	output logic signed [rpbt_pkg::BOUND_W-1:0]  wdata,
	output logic                                 re,
	output logic [ADDR_W-1:0]                    raddr,
	input  logic signed [rpbt_pkg::BOUND_W-1:0]  rdata
);

	localparam int BW = rpbt_pkg::BOUND_W;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TOP0,
		B_TOP1,
		B_LVL,
		B_PART
	} bstate_t;

	bstate_t                       state_q;
	logic [LVL_W-1:0]              k_q;
	logic [LVL_W-1:0]              lvl_q;
	logic [rpbt_pkg::SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]             wptr_q;
	logic [ADDR_W-1:0]             rptr_q;
	logic [ADDR_W-1:0]             jcnt_q;
	logic [1:0]                    p_q;
	logic signed [BW-1:0]          cur_q;
	logic signed [BW-1:0]          hi_q;
	logic [BW-1:0]                 step_q;
	logic [1:0]                    rest_q;
	logic                          done_q;

	logic [ADDR_W-1:0]             top_base;
	logic [ADDR_W-1:0]             here_base;
	logic [ADDR_W-1:0]             up_base;
	logic [3:0]                    gap;
	logic                          last_int;
	logic signed [BW-1:0]          hi_c;
	logic [BW:0]                   diff;
	logic [BW-1:0]                 len_c;
	logic [BW-1:0]                 step_new;
	logic [1:0]                    rest_new;
	logic [BW-1:0]                 step_c;
	logic [1:0]                    rest_c;
	logic [BW:0]                   nb;
	logic signed [BW-1:0]          wv;
	logic                          finish;

	// level bases for the top level, the current level and its parent
	assign top_base  = ADDR_W'(rpbt_pkg::level_base(4'(k_q), 4'(k_q)));
	assign here_base = ADDR_W'(rpbt_pkg::level_base(4'(lvl_q), 4'(k_q)));
	assign up_base   = ADDR_W'(rpbt_pkg::level_base(4'(lvl_q) + 4'd1, 4'(k_q)));

	// parent intervals per level: 4^(k-lvl-1)
	assign gap      = 4'(k_q) - 4'(lvl_q) - 4'd1;
	assign last_int = (jcnt_q == ADDR_W'((32'd1 << {gap, 1'b0}) - 32'd1));

	// parent interval length, new interval takes the prefetched end
	assign hi_c  = (p_q == 2'd0) ? rdata : hi_q;
	assign diff  = {hi_c[BW-1], hi_c} - {cur_q[BW-1], cur_q};
	assign len_c = diff[BW] ? '0 : diff[BW-1:0];

	// step and remainder for ceil(len/4) parts, clamped to 1..4
	always_comb begin
		step_new = '0;
		rest_new = '0;
		priority if (len_c <= BW'(4)) begin
			step_new = len_c;
		end else if (len_c <= BW'(8)) begin
			step_new = len_c >> 1;
			rest_new = {1'b0, len_c[0]};
		end else if (len_c <= BW'(12)) begin
			// three parts: 9..11 give step 3, 12 gives step 4
			if (len_c == BW'(12)) begin
				step_new = BW'(4);
			end else begin
				step_new = BW'(3);
				rest_new = 2'(len_c - BW'(9));
			end
		end else begin
			step_new = len_c >> 2;
			rest_new = len_c[1:0];
		end
	end

	assign step_c = (p_q == 2'd0) ? step_new : step_q;
	assign rest_c = (p_q == 2'd0) ? rest_new : rest_q;

	// next child boundary, clipped at the parent end
	assign nb = {cur_q[BW-1], cur_q} + {1'b0, step_c} + (BW+1)'(rest_c != 2'd0);
	assign wv = ($signed(nb) < $signed({hi_c[BW-1], hi_c})) ? nb[BW-1:0] : hi_c;

	// last store write of the whole build
	assign finish = ((state_q == B_TOP1) && (k_q == LVL_W'(1)))
		|| ((state_q == B_PART) && (p_q == 2'd3) && last_int && (lvl_q == LVL_W'(1)));

	// store port drive
	always_comb begin
		we    = 1'b0;
		waddr = wptr_q;
		wdata = wv;
		re    = 1'b0;
		raddr = rptr_q;
		unique case (state_q)
			B_TOP0: begin
				we    = 1'b1;
				waddr = top_base;
				wdata = rpbt_pkg::BOUND_START;
			end
			B_TOP1: begin
				we    = 1'b1;
				wdata = {1'b0, size_q};
			end
			B_LVL: begin
				we    = 1'b1;
				waddr = here_base;
				wdata = rpbt_pkg::BOUND_START;
				re    = 1'b1;
				raddr = up_base + ADDR_W'(1);
			end
			B_PART: begin
				we = 1'b1;
				re = (p_q == 2'd0) && !last_int;
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= LVL_W'(1);
			lvl_q   <= LVL_W'(1);
			size_q  <= '0;
			wptr_q  <= '0;
			rptr_q  <= '0;
			jcnt_q  <= '0;
			p_q     <= '0;
			cur_q   <= '0;
			hi_q    <= '0;
			step_q  <= '0;
			rest_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						size_q  <= problem_size;
						k_q     <= LVL_W'(rpbt_pkg::levels_for(problem_size,
							4'(MAX_LEVELS)));
						state_q <= B_TOP0;
					end
				end
				B_TOP0: begin
					wptr_q  <= top_base + ADDR_W'(1);
					state_q <= B_TOP1;
				end
				B_TOP1: begin
					if (k_q == LVL_W'(1)) begin
						state_q <= B_IDLE;
					end else begin
						lvl_q   <= k_q - LVL_W'(1);
						state_q <= B_LVL;
					end
				end
				B_LVL: begin
					wptr_q  <= here_base + ADDR_W'(1);
					rptr_q  <= up_base + ADDR_W'(2);
					cur_q   <= rpbt_pkg::BOUND_START;
					jcnt_q  <= '0;
					p_q     <= '0;
					state_q <= B_PART;
				end
				B_PART: begin
					wptr_q <= wptr_q + ADDR_W'(1);
					cur_q  <= wv;
					hi_q   <= hi_c;
					step_q <= step_c;
					rest_q <= rest_c - 2'(rest_c != 2'd0);
					p_q    <= p_q + 2'd1;
					if (p_q == 2'd0 && !last_int) begin
						rptr_q <= rptr_q + ADDR_W'(1);
					end
					if (p_q == 2'd3) begin
						if (last_int) begin
							if (lvl_q == LVL_W'(1)) begin
								state_q <= B_IDLE;
							end else begin
								lvl_q   <= lvl_q - LVL_W'(1);
								state_q <= B_LVL;
							end
						end else begin
							jcnt_q <= jcnt_q + ADDR_W'(1);
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != B_IDLE);
	assign stat.done = done_q;
	assign levels    = k_q;

endmodule

// ----- design/radix4_partition_boundary_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-4 partition boundary table
// Builds the boundary table of a recursive split by four of (-1, n] into a
// store and serves single-boundary reads with range checking.
// ----------------------------------------------------------------------------
// Read request: the store read, the result register and the output register
// lie between acceptance and the response; a rejected read skips the store read.
// Build request: the build sequencer writes the top level and then each lower
// level down to level 1, one store write per cycle, before the response.
// One request in work at a time; a finished response waits in the output register.
// Reset clears control, sets the size to 1, marks the table unbuilt; store kept.
module radix4_partition_boundary_table #(
	parameter int MAX_LEVELS = rpbt_pkg::MAX_LEVELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rpbt_cfg_if.sink cfg,
	rpbt_req_if.sink req,
	rpbt_rsp_if.source rsp
);

	localparam int DEPTH  = (((4 ** (MAX_LEVELS - 1)) - 1) * 4) / 3 + MAX_LEVELS + 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
	localparam int BW     = rpbt_pkg::BOUND_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUILD,
		S_READ,
		S_RESP
	} cstate_t;

	cstate_t                            state_q;
	logic [rpbt_pkg::SIZE_W-1:0]        problem_size_q;
	logic                               built_q;
	logic [LVL_W-1:0]                   levels_built_q;
	logic signed [BW-1:0]               res_bound_q;
	logic [rpbt_pkg::LLEN_W-1:0]        res_llen_q;
	rpbt_pkg::status_t                  res_status_q;
	logic                               rsp_valid_q;
	logic signed [BW-1:0]               rsp_bound_q;
	logic [rpbt_pkg::LCOUNT_W-1:0]      rsp_lcount_q;
	logic [rpbt_pkg::LLEN_W-1:0]        rsp_llen_q;
	rpbt_pkg::status_t                  rsp_status_q;

	logic                               accept;
	logic                               is_build;
	logic                               bld_start;
	rpbt_pkg::bld_stat_t                bld_stat;
	logic [LVL_W-1:0]                   bld_levels;
	logic                               bld_re;
	logic [ADDR_W-1:0]                  bld_raddr;
	logic                               mem_we;
	logic [ADDR_W-1:0]                  mem_waddr;
	logic signed [BW-1:0]               mem_wdata;
	logic                               mem_re;
	logic [ADDR_W-1:0]                  mem_raddr;
	logic signed [BW-1:0]               mem_rdata;

	logic [3:0]                         lv4;
	logic [3:0]                         k4;
	logic [3:0]                         exp4;
	logic                               lvl_ok;
	logic [31:0]                        llen32;
	logic                               pos_ok;
	logic [31:0]                        addr32;
	logic                               rd_go;
	logic                               rsp_load;

	// size register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			problem_size_q <= rpbt_pkg::SIZE_W'(1);
		end else if (cfg.valid) begin
			problem_size_q <= cfg.data;
		end
	end

	// request decode
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_build  = (rpbt_pkg::op_t'(req.op) == rpbt_pkg::OP_BUILD);
	assign bld_start = accept && is_build;

	// read checks and store address
	assign lv4    = 4'(req.level);
	assign k4     = 4'(levels_built_q);
	assign exp4   = k4 - lv4;
	assign lvl_ok = (lv4 != 4'd0) && (lv4 <= k4);
	assign llen32 = (32'd1 << {exp4, 1'b0}) + 32'd1;
	assign pos_ok = (32'(req.position) < llen32);
	assign addr32 = rpbt_pkg::level_base(lv4, k4) + 32'(req.position);
	assign rd_go  = accept && !is_build && built_q && lvl_ok && pos_ok;

	// output register takes a new response when empty or being drained
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// store read port shared with the build sequencer
	assign mem_re    = bld_stat.busy ? bld_re : rd_go;
	assign mem_raddr = bld_stat.busy ? bld_raddr : ADDR_W'(addr32);

	rpbt_build_seq #(
		.MAX_LEVELS (MAX_LEVELS),
		.ADDR_W     (ADDR_W),
		.LVL_W      (LVL_W)
	) u_build (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (bld_start),
		.problem_size (problem_size_q),
		.stat         (bld_stat),
		.levels       (bld_levels),
		.we           (mem_we),
		.waddr        (mem_waddr),
		.wdata        (mem_wdata),
		.re           (bld_re),
		.raddr        (bld_raddr),
		.rdata        (mem_rdata)
	);

	rpbt_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// request control and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			built_q        <= 1'b0;
			levels_built_q <= LVL_W'(1);
			res_bound_q    <= '0;
			res_llen_q     <= '0;
			res_status_q   <= rpbt_pkg::ST_OK;
			rsp_valid_q    <= 1'b0;
			rsp_bound_q    <= '0;
			rsp_lcount_q   <= '0;
			rsp_llen_q     <= '0;
			rsp_status_q   <= rpbt_pkg::ST_OK;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_bound_q <= '0;
						res_llen_q  <= '0;
						if (is_build) begin
							state_q <= S_BUILD;
						end else begin
							priority if (!built_q) begin
								res_status_q <= rpbt_pkg::ST_NOT_BUILT;
								state_q      <= S_RESP;
							end else if (!lvl_ok) begin
								res_status_q <= rpbt_pkg::ST_RANGE;
								state_q      <= S_RESP;
							end else if (!pos_ok) begin
								res_status_q <= rpbt_pkg::ST_RANGE;
								res_llen_q   <= rpbt_pkg::LLEN_W'(llen32);
								state_q      <= S_RESP;
							end else begin
								res_status_q <= rpbt_pkg::ST_OK;
								res_llen_q   <= rpbt_pkg::LLEN_W'(llen32);
								state_q      <= S_READ;
							end
						end
					end
				end
				S_BUILD: begin
					if (bld_stat.done) begin
						levels_built_q <= bld_levels;
						built_q        <= 1'b1;
						res_status_q   <= rpbt_pkg::ST_OK;
						state_q        <= S_RESP;
					end
				end
				S_READ: begin
					res_bound_q <= mem_rdata;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_bound_q  <= res_bound_q;
						rsp_lcount_q <= rpbt_pkg::LCOUNT_W'(levels_built_q);
						rsp_llen_q   <= res_llen_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.boundary     = rsp_bound_q;
	assign rsp.level_count  = rsp_lcount_q;
	assign rsp.level_length = rsp_llen_q;
	assign rsp.status       = rsp_status_q;

endmodule

// ----- design/rpbt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-4 partition boundary table: port checker
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module rpbt_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic signed [rpbt_pkg::BOUND_W-1:0]  rsp_boundary,
	input logic [rpbt_pkg::LCOUNT_W-1:0]        rsp_level_count,
	input logic [rpbt_pkg::LLEN_W-1:0]          rsp_level_length,
	input logic [1:0]                           rsp_status
);

	// stalled response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_boundary)
			&& $stable(rsp_status) && $stable(rsp_level_length))
		else $error("response changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// unbuilt table answers with the reset level count and no data
	a_not_built: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == rpbt_pkg::ST_NOT_BUILT |->
			rsp_level_count == rpbt_pkg::LCOUNT_W'(1) && rsp_level_length == '0
			&& rsp_boundary == '0)
		else $error("unbuilt response carries data");

	// range errors carry no boundary
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == rpbt_pkg::ST_RANGE |-> rsp_boundary == '0)
		else $error("range error with non-zero boundary");

endmodule

bind radix4_partition_boundary_table rpbt_checker u_rpbt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_boundary     (rsp.boundary),
	.rsp_level_count  (rsp.level_count),
	.rsp_level_length (rsp.level_length),
	.rsp_status       (rsp.status)
);
